FILE: design/stdd_pkg.sv
// Package for the sorted triple delta decoder: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package stdd_pkg;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned FIRST_END = HEADER_BYTES + 12;
  localparam int unsigned OFF_W = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] page_byte;
    logic       page_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] subject_value;
    logic [31:0] predicate_value;
    logic [31:0] object_value;
    logic        end_marker;
    logic [31:0] next_page_number;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic full;
  } q_ctl_t;
endpackage

FILE: design/stdd_front.sv
// Front side: input transfer acceptance and a two-entry item queue.
// Depends on stdd_pkg.
`timescale 1ns / 1ps
module stdd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stdd_pkg::in_item_t  in_item,
  output logic                q_valid,
  input  logic                q_take,
  output stdd_pkg::in_item_t  q_item
);
  stdd_pkg::in_item_t mem_r [stdd_pkg::QUEUE_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  stdd_pkg::q_ctl_t ctl;

  assign ctl.full = (cnt_r == 2'(stdd_pkg::QUEUE_DEPTH));
  assign in_stall = ctl.full;
  assign ctl.wr   = in_valid && !ctl.full;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (ctl.wr) mem_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (ctl.wr) wp_r <= !wp_r;
      if (q_take && q_valid) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(ctl.wr) - 2'(q_take && q_valid);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_nostall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !in_stall) else $error("stall while empty");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r) else $error("pointer mismatch");
endmodule

FILE: design/stdd_back.sv
// Back side: decodes queued page bytes into triples, with a two-slot output buffer.
// Depends on stdd_pkg.
`timescale 1ns / 1ps
module stdd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_take,
  input  stdd_pkg::in_item_t  q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output stdd_pkg::out_item_t out_item
);
  logic [stdd_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [31:0] subj_r, subj_nxt, pred_r, pred_nxt, obj_r, obj_nxt;
  logic [31:0] acc_r, acc_nxt, link_r, link_nxt;
  logic [6:0]  code_r, code_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  s_r, p_r, o_r, s_n, p_n, o_n;
  stdd_pkg::out_item_t buf_r [2];
  logic [1:0]  bcnt_r;
  logic        rd_r;
  stdd_pkg::out_item_t r0, r1;
  logic        e0, e1;
  logic [1:0]  n_res;
  logic [3:0]  done;
  logic [31:0] acc_sh;
  logic [6:0]  hc;
  logic [4:0]  rel;
  logic        go, pop;
  logic [7:0]  b;

  assign b      = q_item.page_byte;
  assign pop    = out_valid && !out_stall;
  assign q_take = q_valid && (bcnt_r == 2'd0 || (bcnt_r == 2'd1 && pop));
  assign go     = q_take;
  assign out_valid = (bcnt_r != 2'd0);
  assign out_item  = buf_r[rd_r];
  assign acc_sh = {acc_r[23:0], b};
  assign rel    = off_r - 5'(stdd_pkg::HEADER_BYTES);
  assign done   = 4'(s_r) + 4'(p_r) + 4'(o_r) - rem_r + 4'd1;
  assign hc     = (b[6:5] == 2'b01) ? 7'd64 : b[6:0];

  always_comb begin
    s_n = 3'd0; p_n = 3'd0; o_n = 3'd0;
    if (hc < 7'd4) o_n = 3'(hc) + 3'd1;
    else if (hc < 7'd20) begin
      p_n = 3'((hc - 7'd4) >> 2) + 3'd1;
      o_n = 3'((hc - 7'd4) & 7'd3) + 3'd1;
    end else if (hc >= 7'd64) begin
      s_n = 3'((hc - 7'd64) >> 4) + 3'd1;
      p_n = 3'(((hc - 7'd64) >> 2) & 7'd3) + 3'd1;
      o_n = 3'((hc - 7'd64) & 7'd3) + 3'd1;
    end
  end

  always_comb begin
    off_nxt = off_r; subj_nxt = subj_r; pred_nxt = pred_r; obj_nxt = obj_r;
    acc_nxt = acc_r; link_nxt = link_r; code_nxt = code_r; rem_nxt = rem_r;
    fin_nxt = fin_r; e0 = 1'b0; e1 = 1'b0; n_res = 2'd0;
    if (off_r < 5'(stdd_pkg::HEADER_BYTES)) begin
      if (off_r >= 5'(stdd_pkg::HEADER_BYTES - 4)) link_nxt = {link_r[23:0], b};
    end else if (off_r < 5'(stdd_pkg::FIRST_END)) begin
      acc_nxt = acc_sh;
      if (rel[1:0] == 2'd3) begin
        if (rel == 5'd3) subj_nxt = acc_sh;
        else if (rel == 5'd7) pred_nxt = acc_sh;
        else obj_nxt = acc_sh;
        acc_nxt = '0;
        if (rel == 5'd11) n_res = 2'd1;
      end
    end else if (fin_r) begin
    end else if (rem_r != 4'd0) begin
      acc_nxt = acc_sh;
      if (s_r != 3'd0 && done == 4'(s_r)) begin
        subj_nxt = subj_r + acc_sh; acc_nxt = '0;
      end else if (p_r != 3'd0 && done == 4'(s_r) + 4'(p_r)) begin
        pred_nxt = (s_r != 3'd0) ? acc_sh : pred_r + acc_sh; acc_nxt = '0;
      end else if (done == 4'(s_r) + 4'(p_r) + 4'(o_r)) begin
        obj_nxt = (code_r < 7'd4) ? obj_r + acc_sh + 32'd128 : acc_sh; acc_nxt = '0;
      end
      rem_nxt = rem_r - 4'd1;
      if (rem_nxt == 4'd0) n_res = 2'd1;
    end else if (b == 8'd0) begin
      fin_nxt = 1'b1; n_res = 2'd1; e0 = 1'b1;
    end else if (!b[7]) begin
      obj_nxt = obj_r + 32'(b); n_res = 2'd1;
    end else begin
      code_nxt = hc; acc_nxt = '0;
      rem_nxt = 4'(s_n) + 4'(p_n) + 4'(o_n);
      if (rem_nxt == 4'd0) n_res = 2'd1;
    end
    if (off_r < 5'(stdd_pkg::FIRST_END)) off_nxt = off_r + 5'd1;
    if (q_item.page_last) begin
      if (!fin_nxt) begin
        if (n_res == 2'd1) e1 = 1'b1; else e0 = 1'b1;
        n_res = n_res + 2'd1;
      end
      off_nxt = '0; fin_nxt = 1'b0; rem_nxt = '0; code_nxt = '0; acc_nxt = '0;
    end
    r0 = '{subj_nxt, pred_nxt, obj_nxt, e0, e0 ? link_nxt : 32'd0};
    r1 = '{subj_nxt, pred_nxt, obj_nxt, e1, e1 ? link_nxt : 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0; subj_r <= '0; pred_r <= '0; obj_r <= '0; acc_r <= '0;
      link_r <= '0; code_r <= '0; rem_r <= '0; fin_r <= 1'b0;
      s_r <= '0; p_r <= '0; o_r <= '0; bcnt_r <= '0; rd_r <= 1'b0;
    end else begin
      if (go) begin
        off_r <= off_nxt; subj_r <= subj_nxt; pred_r <= pred_nxt; obj_r <= obj_nxt;
        acc_r <= acc_nxt; link_r <= link_nxt; code_r <= code_nxt; rem_r <= rem_nxt;
        fin_r <= fin_nxt;
        if (rem_r == 4'd0 && off_r >= 5'(stdd_pkg::FIRST_END) && !fin_r) begin
          s_r <= s_n; p_r <= p_n; o_r <= o_n;
        end
      end
      if (go) begin
        if (bcnt_r == 2'd0 || pop) begin
          rd_r <= 1'b0;
          buf_r[0] <= r0; buf_r[1] <= r1;
          bcnt_r <= n_res;
        end
      end else if (pop) begin
        rd_r <= 1'b1;
        bcnt_r <= bcnt_r - 2'd1;
      end
    end
  end

  a_bcnt: assert property (@(posedge clk) disable iff (!rst_n) bcnt_r <= 2'd2)
    else $error("result buffer overflow");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> (bcnt_r == 2'd0 || pop)) else $error("take while buffer busy");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n) rem_r <= 4'd12)
    else $error("payload count out of range");
endmodule

FILE: design/sorted_triple_delta_decoder.sv
// Top level of the sorted triple delta decoder.
// Depends on stdd_pkg, stdd_front, stdd_back.
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_page_byte, in_page_last
//   out     | output    | out_valid, out_stall, out_*_value, out_end_marker,
//           |           | out_next_page_number
// One byte per cycle sustained while out is not stalled; a byte giving two
// results holds the decoder while the result buffer drains, and the two-entry
// byte queue keeps input transfers flowing meanwhile. Reset is synchronous and
// clears all page state. Stalls on out back up the byte queue and then raise
// in_stall.
`timescale 1ns / 1ps
module sorted_triple_delta_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_page_byte,
  input  logic        in_page_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_subject_value,
  output logic [31:0] out_predicate_value,
  output logic [31:0] out_object_value,
  output logic        out_end_marker,
  output logic [31:0] out_next_page_number
);
  stdd_pkg::in_item_t  in_item, q_item;
  stdd_pkg::out_item_t out_item;
  logic q_valid, q_take;

  assign in_item = '{in_page_byte, in_page_last};

  stdd_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_item,
    .q_valid, .q_take, .q_item);
  stdd_back u_back (.clk, .rst_n, .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_item);

  assign out_subject_value    = out_item.subject_value;
  assign out_predicate_value  = out_item.predicate_value;
  assign out_object_value     = out_item.object_value;
  assign out_end_marker       = out_item.end_marker;
  assign out_next_page_number = out_item.next_page_number;
endmodule

FILE: dv/sorted_triple_delta_decoder_tb.sv
// Testbench for sorted_triple_delta_decoder: streams generated leaf pages and
// checks each decoded triple and end marker against a predictor of the decoder.
// Depends on stdd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module sorted_triple_delta_decoder_tb;

  class triple_scoreboard;
    logic [4:0]  offset;
    logic [31:0] subj, pred, obj, acc, link;
    logic [6:0]  code;
    logic [3:0]  remaining;
    bit          finished;
    stdd_pkg::out_item_t pending[$];
    int          errors;

    function void clear();
      offset = 0; subj = 0; pred = 0; obj = 0; acc = 0; link = 0;
      code = 0; remaining = 0; finished = 0; errors = 0;
    endfunction

    static function void sizes(logic [6:0] c, output int s, output int p, output int o);
      s = 0; p = 0; o = 0;
      if (c < 4) begin
        o = c + 1;
      end else if (c < 20) begin
        p = ((c - 4) >> 2) + 1;
        o = ((c - 4) & 3) + 1;
      end else if (c >= 64) begin
        s = ((c - 64) >> 4) + 1;
        p = (((c - 64) >> 2) & 3) + 1;
        o = ((c - 64) & 3) + 1;
      end
    endfunction

    function void push_triple(bit is_end);
      stdd_pkg::out_item_t r;
      r.subject_value = subj;
      r.predicate_value = pred;
      r.object_value = obj;
      r.end_marker = is_end;
      r.next_page_number = is_end ? link : 32'd0;
      pending = {pending, r};
    endfunction

    function void note_input(logic [7:0] b, logic last);
      int s, p, o, total, done, rel;
      logic [6:0] c;
      if (offset < stdd_pkg::HEADER_BYTES) begin
        if (offset >= stdd_pkg::HEADER_BYTES - 4) link = {link[23:0], b};
      end else if (offset < stdd_pkg::FIRST_END) begin
        rel = offset - stdd_pkg::HEADER_BYTES;
        acc = {acc[23:0], b};
        if ((rel & 3) == 3) begin
          if (rel == 3) subj = acc;
          else if (rel == 7) pred = acc;
          else obj = acc;
          acc = 0;
          if (rel == 11) push_triple(0);
        end
      end else if (finished) begin
      end else if (remaining != 0) begin
        sizes(code, s, p, o);
        total = s + p + o;
        done = total - remaining + 1;
        acc = {acc[23:0], b};
        if (s != 0 && done == s) begin
          subj += acc; acc = 0;
        end else if (p != 0 && done == s + p) begin
          if (s != 0) pred = acc;
          else pred += acc;
          acc = 0;
        end else if (done == total) begin
          if (code < 4) obj += acc + 32'd128;
          else obj = acc;
          acc = 0;
        end
        remaining--;
        if (remaining == 0) push_triple(0);
      end else if (b == 0) begin
        finished = 1;
        push_triple(1);
      end else if (b < 8'h80) begin
        obj += b;
        push_triple(0);
      end else begin
        c = b[6:0];
        if (c >= 32 && c < 64) c = 64;
        sizes(c, s, p, o);
        code = c;
        acc = 0;
        remaining = s + p + o;
        if (remaining == 0) push_triple(0);
      end
      if (offset < stdd_pkg::FIRST_END) offset++;
      if (last) begin
        if (!finished) push_triple(1);
        offset = 0; finished = 0; remaining = 0; code = 0; acc = 0;
      end
    endfunction

    function void check_result(stdd_pkg::out_item_t got);
      stdd_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.subject_value !== want.subject_value) begin
        $error("subject_value expected %h got %h", want.subject_value, got.subject_value);
        errors++;
      end
      if (got.predicate_value !== want.predicate_value) begin
        $error("predicate_value expected %h got %h", want.predicate_value,
               got.predicate_value);
        errors++;
      end
      if (got.object_value !== want.object_value) begin
        $error("object_value expected %h got %h", want.object_value, got.object_value);
        errors++;
      end
      if (got.end_marker !== want.end_marker) begin
        $error("end_marker expected %b got %b", want.end_marker, got.end_marker);
        errors++;
      end
      if (got.next_page_number !== want.next_page_number) begin
        $error("next_page_number expected %h got %h", want.next_page_number,
               got.next_page_number);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_page_byte;
  logic        in_page_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_subject_value;
  logic [31:0] out_predicate_value;
  logic [31:0] out_object_value;
  logic        out_end_marker;
  logic [31:0] out_next_page_number;

  triple_scoreboard sb;
  int   idle_pct;
  int   stall_pct;
  int   byte_count;
  int   cycles;
  logic [7:0] page[$];

  sorted_triple_delta_decoder DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0; in_valid = 0; in_page_byte = 0; in_page_last = 0; out_stall = 0;
    idle_pct = 0; stall_pct = 0; cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_subject_value, out_predicate_value, out_object_value,
                        out_end_marker, out_next_page_number});
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_page_byte <= b;
    in_page_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(b, last);
    byte_count++;
  endtask

  task automatic send_page();
    for (int i = 0; i < page.size(); i++) send_byte(page[i], i == page.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic build_page();
    int s, p, o, n, kind;
    logic [7:0] h;
    page = {};
    kind = $urandom_range(19);
    if (kind == 0) begin
      n = $urandom_range(1, 23);
      repeat (n) page = {page, 8'($urandom)};
      return;
    end
    repeat (24) page = {page, 8'($urandom)};
    n = $urandom_range(1, 10);
    repeat (n) begin
      if ($urandom_range(2) == 0) begin
        page = {page, 8'($urandom_range(1, 127))};
      end else begin
        h = 8'h80 | 8'($urandom_range(127));
        page = {page, h};
        triple_scoreboard::sizes((h[6:0] >= 32 && h[6:0] < 64) ? 7'd64 : h[6:0], s, p, o);
        repeat (s + p + o) page = {page, 8'($urandom)};
      end
    end
    if (kind <= 4) begin
      page = {page, 8'h00};
      repeat ($urandom_range(0, 4)) page = {page, 8'($urandom)};
    end else if (kind <= 8) begin
      n = $urandom_range(1, 3);
      if (page.size() > 25 + n) repeat (n) void'(page.pop_back());
    end else if (kind == 9) begin
      repeat ($urandom_range(1, 6)) page = {page, 8'($urandom)};
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    byte_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    page = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
            8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'hFF, 8'hF0,
            8'h01, 8'h7F, 8'h80, 8'hFF, 8'h94, 8'h84, 8'h01, 8'h02,
            8'h93, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
            8'hA0, 8'h01, 8'h02, 8'h03, 8'h9F, 8'hFF, 8'hAA, 8'hBB, 8'hCC,
            8'h00, 8'h55, 8'hFF};
    send_page();
    page = {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
    send_page();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 60) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 60) : 0;
      byte_count = 0;
      while (byte_count < 75) begin
        build_page();
        send_page();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
